// File: hw/rtl/esp_pkg.sv
// shared widths, register indexes and pipeline stage layout for the
// edge stream partition start block; no dependencies
package esp_pkg;

   // field and register widths
   localparam int NODE_W  = 16;
   localparam int ROUND_W = 10;
   localparam int HC_W    = 9;
   localparam int HIDX_W  = 8;
   localparam int EDGE_W  = 2 * NODE_W;
   localparam int TOT_W   = 41;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 1;

   localparam logic [HC_W-1:0] MAX_HANDLES = HC_W'(256);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HANDLE_COUNT = 2'd2;

   // reset values
   localparam logic [NODE_W-1:0]  NODE_COUNT_RST   = NODE_W'(2);
   localparam logic [ROUND_W-1:0] ROUND_COUNT_RST  = ROUND_W'(1);
   localparam logic [HC_W-1:0]    HANDLE_COUNT_RST = HC_W'(1);

   // divider shapes: share = total / handles, round = offset / edges
   localparam int DA_QUO_W = TOT_W;
   localparam int DA_STEPS = 7;
   localparam int DA_ST    = (DA_QUO_W + DA_STEPS - 1) / DA_STEPS;
   localparam int DB_QUO_W = ROUND_W;
   localparam int DB_STEPS = 2;
   localparam int DB_ST    = (DB_QUO_W + DB_STEPS - 1) / DB_STEPS;

   // pipeline positions
   localparam int P_IN  = 0;
   localparam int P_TOT = 1;
   localparam int P_DA  = 2;
   localparam int P_OFS = P_DA + DA_ST;
   localparam int P_DB  = P_OFS + 1;
   localparam int P_SR  = P_DB + DB_ST;
   localparam int P_OUT = P_SR + NODE_W;
   localparam int NST   = P_OUT + 1;

endpackage

// File: hw/rtl/esp_div_pipe.sv
// pipelined restoring divider with a sideband that travels with each request
// depends on nothing; stage load enables come from the owner's flow control
module esp_div_pipe #(
   parameter int DEN_W  = 9,
   parameter int QUO_W  = 41,
   parameter int STEPS  = 7,
   parameter int SIDE_W = 8,
   parameter int STAGES = (QUO_W + STEPS - 1) / STEPS
) (
   input  logic              clock,
   input  logic [STAGES-1:0] en,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [QUO_W-1:0]  in_bits,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic [QUO_W-1:0]  out_quo,
   output logic [DEN_W-1:0]  out_rem,
   output logic [SIDE_W-1:0] out_side
);

   logic [DEN_W-1:0]  rem_ff  [STAGES];
   logic [QUO_W-1:0]  bits_ff [STAGES];
   logic [DEN_W-1:0]  den_ff  [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];
   logic [DEN_W-1:0]  rem_in  [STAGES];
   logic [QUO_W-1:0]  bits_in [STAGES];

   // several shift-subtract steps per stage
   always_comb begin
      logic [DEN_W-1:0] r;
      logic [QUO_W-1:0] b;
      logic [DEN_W-1:0] d;
      logic [DEN_W:0]   wide;
      logic [DEN_W:0]   diff;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            r = in_rem;
            b = in_bits;
            d = in_den;
         end else begin
            r = rem_ff[s-1];
            b = bits_ff[s-1];
            d = den_ff[s-1];
         end
         for (int j = 0; j < STEPS; j++) begin
            if (s * STEPS + j < QUO_W) begin
               wide = {r, b[QUO_W-1]};
               diff = wide - {1'b0, d};
               if (wide >= {1'b0, d}) begin
                  r = diff[DEN_W-1:0];
                  b = {b[QUO_W-2:0], 1'b1};
               end else begin
                  r = wide[DEN_W-1:0];
                  b = {b[QUO_W-2:0], 1'b0};
               end
            end
         end
         rem_in[s]  = r;
         bits_in[s] = b;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            den_ff[s]  <= (s == 0) ? in_den : den_ff[s-1];
            side_ff[s] <= (s == 0) ? in_side : side_ff[s-1];
         end
      end
   end

   assign out_quo  = bits_ff[STAGES-1];
   assign out_rem  = rem_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

// File: hw/rtl/esp_row_search.sv
// bit-by-bit search for the greatest row whose preceding pair count is below q,
// one row bit per stage; depends on nothing
module esp_row_search #(
   parameter int NODE_W = 16,
   parameter int SIDE_W = 8,
   parameter int Q_W    = 2 * NODE_W
) (
   input  logic              clock,
   input  logic [NODE_W-1:0] en,
   input  logic [NODE_W-1:0] node_count,
   input  logic [Q_W-1:0]    in_q,
   input  logic [SIDE_W-1:0] in_side,
   output logic [NODE_W-1:0] out_row,
   output logic [Q_W-1:0]    out_sum,
   output logic [Q_W-1:0]    out_q,
   output logic [SIDE_W-1:0] out_side
);

   logic [NODE_W-1:0] row_ff  [NODE_W];
   logic [Q_W-1:0]    sum_ff  [NODE_W];
   logic [Q_W-1:0]    q_ff    [NODE_W];
   logic [SIDE_W-1:0] side_ff [NODE_W];
   logic [NODE_W-1:0] row_in  [NODE_W];
   logic [Q_W-1:0]    sum_in  [NODE_W];

   // last usable row n-2 and weight base 2n-1
   logic [NODE_W:0] row_lim;
   logic [NODE_W:0] wgt_base;
   assign row_lim  = {1'b0, node_count} - (NODE_W+1)'(2);
   assign wgt_base = {node_count, 1'b0} - (NODE_W+1)'(1);

   // try one more row bit per stage
   always_comb begin
      logic [NODE_W-1:0]   r;
      logic [Q_W-1:0]      sm;
      logic [Q_W-1:0]      qv;
      logic [NODE_W-1:0]   cand;
      logic [NODE_W:0]     wgt;
      logic [2*NODE_W:0]   prod;
      logic [Q_W-1:0]      cand_sum;
      for (int s = 0; s < NODE_W; s++) begin
         if (s == 0) begin
            r  = '0;
            sm = '0;
            qv = in_q;
         end else begin
            r  = row_ff[s-1];
            sm = sum_ff[s-1];
            qv = q_ff[s-1];
         end
         cand     = r | (NODE_W'(1) << (NODE_W - 1 - s));
         wgt      = wgt_base - {1'b0, cand};
         prod     = {{(NODE_W+1){1'b0}}, cand} * {{NODE_W{1'b0}}, wgt};
         cand_sum = prod[Q_W:1];
         if ({1'b0, cand} <= row_lim && cand_sum < qv) begin
            row_in[s] = cand;
            sum_in[s] = cand_sum;
         end else begin
            row_in[s] = r;
            sum_in[s] = sm;
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int s = 0; s < NODE_W; s++) begin
         if (en[s]) begin
            row_ff[s]  <= row_in[s];
            sum_ff[s]  <= sum_in[s];
            q_ff[s]    <= (s == 0) ? in_q : q_ff[s-1];
            side_ff[s] <= (s == 0) ? in_side : side_ff[s-1];
         end
      end
   end

   assign out_row  = row_ff[NODE_W-1];
   assign out_sum  = sum_ff[NODE_W-1];
   assign out_q    = q_ff[NODE_W-1];
   assign out_side = side_ff[NODE_W-1];

endmodule

// File: hw/rtl/edge_stream_partition_start.sv
// Pipelined start-position calculator: takes one handle index per cycle while
// the output is not stalled, and returns the row, column, round and advance
// count where that handle's share of the repeated upper-triangle pair
// enumeration begins. Throughput is one request per clock while rsp_tready
// keeps the output moving; the pipeline holds the 41-step share divider (six
// stages), the 10-step round divider (five stages) and the one-bit-per-stage
// row search (sixteen stages). Any stage that is empty is filled even while
// the output waits. Registers may only be written while nothing is in flight.
// Depends on esp_pkg, esp_div_pipe and esp_row_search.
module edge_stream_partition_start (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_we,
   input  logic [esp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [esp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [esp_pkg::REQ_DATA_W-1:0]     req_tdata,  // handle_index[7:0]
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // start_row[15:0], start_col[31:16], start_round[41:32],
   // advance_count[82:42], zero fill[87:83]
   output logic [esp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [esp_pkg::RSP_USER_W-1:0]     rsp_tuser   // handle_ok[0]
);

   localparam int NST    = esp_pkg::NST;
   localparam int NODE_W = esp_pkg::NODE_W;
   localparam int EDGE_W = esp_pkg::EDGE_W;
   localparam int TOT_W  = esp_pkg::TOT_W;
   localparam int HC_W   = esp_pkg::HC_W;
   localparam int HIDX_W = esp_pkg::HIDX_W;
   localparam int RND_W  = esp_pkg::ROUND_W;
   localparam int SA_W   = HIDX_W + 2 + EDGE_W;
   localparam int SB_W   = TOT_W + 2;
   localparam int SS_W   = RND_W + TOT_W + 2;

   // configuration registers
   logic [NODE_W-1:0] node_count_ff;
   logic [RND_W-1:0]  round_count_ff;
   logic [HC_W-1:0]   handle_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= esp_pkg::NODE_COUNT_RST;
         round_count_ff  <= esp_pkg::ROUND_COUNT_RST;
         handle_count_ff <= esp_pkg::HANDLE_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            esp_pkg::CSR_NODE_COUNT:   node_count_ff   <= csr_wdata[NODE_W-1:0];
            esp_pkg::CSR_ROUND_COUNT:  round_count_ff  <= csr_wdata[RND_W-1:0];
            esp_pkg::CSR_HANDLE_COUNT: handle_count_ff <= csr_wdata[HC_W-1:0];
            default: ;
         endcase
      end
   end

   // valid bits and per-stage load enables
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = en[0] ? req_tvalid : v_ff[0];
      for (int k = 1; k < NST; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_tready = en[0];

   // stage 0: handle checks and edge count
   logic [HC_W-1:0]     hc_eff;
   logic [2*NODE_W-1:0] npair;
   logic [HIDX_W-1:0]   h0_ff;
   logic                ok0_ff;
   logic                last0_ff;
   logic [HC_W-1:0]     hc0_ff;
   logic [EDGE_W-1:0]   e0_ff;

   assign hc_eff = (handle_count_ff > esp_pkg::MAX_HANDLES) ? esp_pkg::MAX_HANDLES
                                                           : handle_count_ff;
   assign npair  = {{NODE_W{1'b0}}, node_count_ff}
                 * {{NODE_W{1'b0}}, node_count_ff - NODE_W'(1)};

   always_ff @(posedge clock) begin
      if (en[esp_pkg::P_IN]) begin
         h0_ff    <= req_tdata[HIDX_W-1:0];
         ok0_ff   <= (hc_eff != '0) && ({1'b0, req_tdata[HIDX_W-1:0]} < hc_eff);
         last0_ff <= ({1'b0, req_tdata[HIDX_W-1:0]} == hc_eff - HC_W'(1));
         hc0_ff   <= hc_eff;
         e0_ff    <= npair >> 1;
      end
   end

   // stage 1: total advances
   logic [EDGE_W+RND_W-1:0] tw;
   logic [TOT_W-1:0]        t1_ff;
   logic [HIDX_W-1:0]       h1_ff;
   logic                    ok1_ff;
   logic                    last1_ff;
   logic [HC_W-1:0]         hc1_ff;
   logic [EDGE_W-1:0]       e1_ff;

   assign tw = {{RND_W{1'b0}}, e0_ff} * {{EDGE_W{1'b0}}, round_count_ff};

   always_ff @(posedge clock) begin
      if (en[esp_pkg::P_TOT]) begin
         t1_ff    <= tw[TOT_W-1:0];
         h1_ff    <= h0_ff;
         ok1_ff   <= ok0_ff;
         last1_ff <= last0_ff;
         hc1_ff   <= hc0_ff;
         e1_ff    <= e0_ff;
      end
   end

   // share = total / handles
   logic [TOT_W-1:0] share;
   logic [HC_W-1:0]  share_rem;
   logic [SA_W-1:0]  sa_out;

   esp_div_pipe #(
      .DEN_W  (HC_W),
      .QUO_W  (esp_pkg::DA_QUO_W),
      .STEPS  (esp_pkg::DA_STEPS),
      .SIDE_W (SA_W)
   ) u_div_share (
      .clock    (clock),
      .en       (en[esp_pkg::P_DA +: esp_pkg::DA_ST]),
      .in_rem   ('0),
      .in_bits  (t1_ff),
      .in_den   (hc1_ff),
      .in_side  ({h1_ff, ok1_ff, last1_ff, e1_ff}),
      .out_quo  (share),
      .out_rem  (share_rem),
      .out_side (sa_out)
   );

   // offset and advance count
   logic [HIDX_W-1:0]       ha;
   logic                    oka;
   logic                    lasta;
   logic [EDGE_W-1:0]       ea;
   logic [TOT_W+HIDX_W-1:0] ow;
   logic [TOT_W-1:0]        ofs_ff;
   logic [TOT_W-1:0]        adv_ff;
   logic                    ok8_ff;
   logic                    ez8_ff;
   logic [EDGE_W-1:0]       e8_ff;

   assign {ha, oka, lasta, ea} = sa_out;
   assign ow = {{HIDX_W{1'b0}}, share} * {{TOT_W{1'b0}}, ha};

   always_ff @(posedge clock) begin
      if (en[esp_pkg::P_OFS]) begin
         ofs_ff <= ow[TOT_W-1:0];
         adv_ff <= lasta ? share + {{(TOT_W-HC_W){1'b0}}, share_rem} : share;
         ok8_ff <= oka;
         ez8_ff <= (ea == '0);
         e8_ff  <= ea;
      end
   end

   // round = offset / edges, pair index from the remainder
   logic [RND_W-1:0]  rnd;
   logic [EDGE_W-1:0] pair_rem;
   logic [SB_W-1:0]   sb_out;

   esp_div_pipe #(
      .DEN_W  (EDGE_W),
      .QUO_W  (esp_pkg::DB_QUO_W),
      .STEPS  (esp_pkg::DB_STEPS),
      .SIDE_W (SB_W)
   ) u_div_round (
      .clock    (clock),
      .en       (en[esp_pkg::P_DB +: esp_pkg::DB_ST]),
      .in_rem   (EDGE_W'(ofs_ff[TOT_W-1:RND_W])),
      .in_bits  (ofs_ff[RND_W-1:0]),
      .in_den   (e8_ff),
      .in_side  ({adv_ff, ok8_ff, ez8_ff}),
      .out_quo  (rnd),
      .out_rem  (pair_rem),
      .out_side (sb_out)
   );

   // starting row search
   logic [NODE_W-1:0] row;
   logic [EDGE_W-1:0] row_sum;
   logic [EDGE_W-1:0] qf;
   logic [SS_W-1:0]   ss_out;

   esp_row_search #(
      .NODE_W (NODE_W),
      .SIDE_W (SS_W),
      .Q_W    (EDGE_W)
   ) u_row_search (
      .clock      (clock),
      .en         (en[esp_pkg::P_SR +: NODE_W]),
      .node_count (node_count_ff),
      .in_q       (pair_rem + EDGE_W'(1)),
      .in_side    ({rnd, sb_out}),
      .out_row    (row),
      .out_sum    (row_sum),
      .out_q      (qf),
      .out_side   (ss_out)
   );

   // output register with zeroing of unused fields
   logic [RND_W-1:0]  rnd_f;
   logic [TOT_W-1:0]  adv_f;
   logic              ok_f;
   logic              ez_f;
   logic [EDGE_W-1:0] col_w;
   logic [NODE_W-1:0] row_ff;
   logic [NODE_W-1:0] col_ff;
   logic [RND_W-1:0]  rnd_ff;
   logic [TOT_W-1:0]  adv_o_ff;
   logic              ok_ff;

   assign {rnd_f, adv_f, ok_f, ez_f} = ss_out;
   assign col_w = qf - row_sum + {{(EDGE_W-NODE_W){1'b0}}, row} - EDGE_W'(1);

   always_ff @(posedge clock) begin
      if (en[esp_pkg::P_OUT]) begin
         row_ff   <= (ok_f && !ez_f) ? row : '0;
         col_ff   <= (ok_f && !ez_f) ? col_w[NODE_W-1:0] : '0;
         rnd_ff   <= (ok_f && !ez_f) ? rnd_f : '0;
         adv_o_ff <= ok_f ? adv_f : '0;
         ok_ff    <= ok_f;
      end
   end

   assign rsp_tvalid = v_ff[NST-1];
   assign rsp_tdata  = {{(esp_pkg::RSP_DATA_W-TOT_W-RND_W-2*NODE_W){1'b0}},
                        adv_o_ff, rnd_ff, col_ff, row_ff};
   assign rsp_tuser  = ok_ff;

endmodule

// File: hw/rtl/esp_checker.sv
// port-level checks for edge_stream_partition_start, bound to the top level
// depends on esp_pkg
module esp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_we,
   input logic [esp_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [esp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [esp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [esp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [esp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a rejected handle carries no position
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("nonzero fields on a rejected handle");

   // a free or draining output never blocks a new request
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled while output can move");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                        && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind edge_stream_partition_start esp_checker u_esp_checker (.*);

// File: tb/sv/tb_edge_stream_partition_start.sv
// testbench for edge_stream_partition_start: random and directed handle requests
// checked against an in-bench start-position predictor; depends on esp_pkg and the rtl
module tb_edge_stream_partition_start;

   typedef struct packed {
      logic [15:0] row;
      logic [15:0] col;
      logic [9:0]  rnd;
      logic [40:0] adv;
      logic        ok;
   } start_type;

   // expected start positions and the predictor's copy of the registers
   class start_scoreboard;
      start_type   pending[$];
      logic [15:0] nodes;
      logic [9:0]  rounds;
      logic [8:0]  handles;
      int          errors;

      function new();
         nodes = esp_pkg::NODE_COUNT_RST;
         rounds = esp_pkg::ROUND_COUNT_RST;
         handles = esp_pkg::HANDLE_COUNT_RST;
         errors = 0;
      endfunction

      // pairs in rows 0..r-1
      function longint unsigned rows_sum(longint unsigned r, longint unsigned n);
         return (r * (2 * n - 1 - r)) / 2;
      endfunction

      function void note_request(logic [7:0] h);
         start_type e;
         longint unsigned hc, n, edges, total, share, offset, q, lo, hi, mid;
         e = '0;
         hc = handles;
         n = nodes;
         if (hc > esp_pkg::MAX_HANDLES) hc = esp_pkg::MAX_HANDLES;
         if (hc != 0 && h < hc) begin
            edges = (n >= 2) ? (n * (n - 1)) / 2 : 0;
            total = edges * rounds;
            share = total / hc;
            e.adv = (h == hc - 1) ? 41'(share + total % hc) : 41'(share);
            e.ok = 1'b1;
            if (edges != 0) begin
               offset = h * share;
               e.rnd = 10'(offset / edges);
               q = offset % edges + 1;
               lo = 0;
               hi = n - 2;
               // greatest row whose preceding pair count is below q
               while (lo < hi) begin
                  mid = lo + (hi - lo + 1) / 2;
                  if (rows_sum(mid, n) < q) lo = mid;
                  else hi = mid - 1;
               end
               e.row = 16'(lo);
               e.col = 16'(q - rows_sum(lo, n) + lo - 1);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [esp_pkg::RSP_DATA_W-1:0] d, logic ok);
         start_type e;
         start_type a;
         a.row = d[15:0];
         a.col = d[31:16];
         a.rnd = d[41:32];
         a.adv = d[82:42];
         a.ok = ok;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", a);
            return;
         end
         e = pending.pop_front();
         if (a !== e || d[87:83] !== 5'd0) begin
            errors++;
            if (errors <= 10)
               $display("mismatch row %0d/%0d col %0d/%0d rnd %0d/%0d adv %0d/%0d ok %0d/%0d",
                  e.row, a.row, e.col, a.col, e.rnd, a.rnd, e.adv, a.adv, e.ok, a.ok);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_we = 0;
   logic [esp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [esp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 0, req_tready;
   logic [esp_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [esp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [esp_pkg::RSP_USER_W-1:0] rsp_tuser;

   start_scoreboard sb = new();
   int  req_idle_pct = 26, rsp_idle_pct = 26;
   bit  rsp_hold = 0;
   int  quiet_cycles = 0;

   always #2 clock = ~clock;

   edge_stream_partition_start dut (.*);

   // predictor and checker sample at the edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_request(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset || rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("FAIL edge_stream_partition_start");
         $finish;
      end
   end

   task automatic write_reg(logic [esp_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= esp_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == esp_pkg::CSR_NODE_COUNT) sb.nodes = 16'(val);
      else if (idx == esp_pkg::CSR_ROUND_COUNT) sb.rounds = 10'(val);
      else if (idx == esp_pkg::CSR_HANDLE_COUNT) sb.handles = 9'(val);
   endtask

   // offer one request and return at the edge that accepts it, valid still high
   task automatic send_request(logic [7:0] h);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= h;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (esp_pkg::NST + 5) @(posedge clock);
   endtask

   task automatic configure(int unsigned n, int unsigned r, int unsigned hc);
      drain();
      write_reg(esp_pkg::CSR_NODE_COUNT, n);
      write_reg(esp_pkg::CSR_ROUND_COUNT, r);
      write_reg(esp_pkg::CSR_HANDLE_COUNT, hc);
   endtask

   initial begin
      int unsigned hc;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes of the index
      send_request(8'd0);
      send_request(8'd1);
      send_request(8'd255);
      configure(65535, 1023, 256);
      send_request(8'd0);
      send_request(8'd1);
      send_request(8'd128);
      send_request(8'd255);
      // zero handle count
      configure(10, 3, 0);
      send_request(8'd0);
      send_request(8'd5);
      // handle count above the maximum saturates
      configure(100, 7, 511);
      send_request(8'd0);
      send_request(8'd255);
      // zero rounds
      configure(65535, 0, 4);
      send_request(8'd0);
      send_request(8'd3);
      send_request(8'd4);
      // fewer than two nodes, then exactly two
      configure(1, 5, 3);
      send_request(8'd2);
      configure(0, 5, 3);
      send_request(8'd1);
      configure(2, 1023, 3);
      send_request(8'd0);
      send_request(8'd2);

      // random phases; one long stretch with no idling
      for (int ph = 0; ph < 17; ph++) begin
         if ($urandom_range(3) == 0)
            configure($urandom_range(1) ? $urandom_range(65535) : $urandom_range(2, 40),
                      $urandom_range(1023), $urandom_range(511));
         else
            configure($urandom_range(2, 65535), $urandom_range(1, 1023),
                      $urandom_range(1, 256));
         hc = sb.handles;
         if (ph == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 26;
            rsp_idle_pct = 26;
         end
         if (ph == 6) begin
            // receiver holds off while requests keep coming
            fork
               begin
                  rsp_hold = 1;
                  repeat (150) @(posedge clock);
                  rsp_hold = 0;
               end
            join_none
         end
         for (int k = 0; k < 50; k++) begin
            if (hc != 0 && $urandom_range(9) != 0)
               send_request(8'($urandom_range(hc > 256 ? 255 : hc - 1)));
            else
               send_request(8'($urandom_range(255)));
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS edge_stream_partition_start");
      else
         $display("FAIL edge_stream_partition_start");
      $finish;
   end
endmodule
